>>> rtl/core/bbs_pkg.sv
// Shared types, character codes and bracket helper functions for the bracket span block.
package bbs_pkg;

   // Fixed payload widths
   localparam int SYM_W = 8;
   localparam int LEN_W = 7;

   // Bracket characters
   localparam logic [SYM_W-1:0] CH_ROUND_OPEN   = 8'h28;
   localparam logic [SYM_W-1:0] CH_ROUND_CLOSE  = 8'h29;
   localparam logic [SYM_W-1:0] CH_SQUARE_OPEN  = 8'h5B;
   localparam logic [SYM_W-1:0] CH_SQUARE_CLOSE = 8'h5D;
   localparam logic [SYM_W-1:0] CH_CURLY_OPEN   = 8'h7B;
   localparam logic [SYM_W-1:0] CH_CURLY_CLOSE  = 8'h7D;
   localparam logic [SYM_W-1:0] CH_ANGLE_OPEN   = 8'h3C;
   localparam logic [SYM_W-1:0] CH_ANGLE_CLOSE  = 8'h3E;

   // Kind of a pending opener, kept next to its position on the stack
   typedef enum logic [1:0] {
      BR_ROUND,
      BR_SQUARE,
      BR_CURLY,
      BR_ANGLE
   } bracket_kind_type;

   localparam int KIND_W = 2;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_LOAD,
      ST_MATCH,
      ST_BK_RD,
      ST_BK_NX,
      ST_BK_WR,
      ST_EM_RD,
      ST_EM_CAP
   } bbs_state_type;

   // One result beat
   typedef struct packed {
      logic [LEN_W-1:0] span_length;
      logic             end_of_run;
   } bbs_beat_type;

   function automatic logic is_opener(input logic [SYM_W-1:0] sym);
      return (sym == CH_ROUND_OPEN) || (sym == CH_SQUARE_OPEN) ||
             (sym == CH_CURLY_OPEN) || (sym == CH_ANGLE_OPEN);
   endfunction

   function automatic bracket_kind_type opener_kind(input logic [SYM_W-1:0] sym);
      bracket_kind_type kind;
      case (sym)
         CH_SQUARE_OPEN: kind = BR_SQUARE;
         CH_CURLY_OPEN:  kind = BR_CURLY;
         CH_ANGLE_OPEN:  kind = BR_ANGLE;
         default:        kind = BR_ROUND;
      endcase
      return kind;
   endfunction

   function automatic logic closer_matches(input bracket_kind_type kind,
                                           input logic [SYM_W-1:0] sym);
      logic hit;
      case (kind)
         BR_ROUND:  hit = (sym == CH_ROUND_CLOSE);
         BR_SQUARE: hit = (sym == CH_SQUARE_CLOSE);
         BR_CURLY:  hit = (sym == CH_CURLY_CLOSE);
         BR_ANGLE:  hit = (sym == CH_ANGLE_CLOSE);
         default:   hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

>>> rtl/core/bbs_if.sv
// Valid/ready channel interfaces for the request and response sides.
interface bbs_req_if
   import bbs_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             is_final;

   modport source (output valid, output symbol, output is_final, input ready);
   modport sink   (input valid, input symbol, input is_final, output ready);
endinterface

interface bbs_rsp_if
   import bbs_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] span_length;
   logic             end_of_run;

   modport source (output valid, output span_length, output end_of_run, input ready);
   modport sink   (input valid, input span_length, input end_of_run, output ready);
endinterface

>>> rtl/core/bbs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read, held between reads
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/bbs_out_stage.sv
// Output register that holds one result beat until the response side takes it.
module bbs_out_stage
   import bbs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  bbs_beat_type beat,
   output logic         free,
   bbs_rsp_if.source    rsp
);

   logic         valid_ff;
   logic         valid_in;
   bbs_beat_type beat_ff;

   assign free = !valid_ff || rsp.ready;

   // Fill on load, drop once the beat is taken
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= beat;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.span_length = beat_ff.span_length;
   assign rsp.end_of_run  = beat_ff.end_of_run;

endmodule

>>> rtl/core/bbs_ctrl.sv
// Sequencer: loads bytes, matches brackets via the stack memory, chains spans and emits.
module bbs_ctrl
   import bbs_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   bbs_req_if.sink                               req,
   // stack memory
   output logic                                  stk_we,
   output logic [$clog2(MAX_LEN)-1:0]            stk_waddr,
   output logic [KIND_W+$clog2(MAX_LEN)-1:0]     stk_wdata,
   output logic                                  stk_re,
   output logic [$clog2(MAX_LEN)-1:0]            stk_raddr,
   input  logic [KIND_W+$clog2(MAX_LEN)-1:0]     stk_rdata,
   // span memory
   output logic                                  span_we,
   output logic [$clog2(MAX_LEN)-1:0]            span_waddr,
   output logic [$clog2(MAX_LEN+1)-1:0]          span_wdata,
   output logic                                  span_re,
   output logic [$clog2(MAX_LEN)-1:0]            span_raddr,
   input  logic [$clog2(MAX_LEN+1)-1:0]          span_rdata,
   // output register
   input  logic                                  out_free,
   output logic                                  out_load,
   output bbs_beat_type                          out_beat
);

   localparam int IW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int SW = CW;

   bbs_state_type    state_ff, state_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    depth_ff, depth_in;
   logic [IW-1:0]    pos_ff, pos_in;
   logic [SYM_W-1:0] sym_ff, sym_in;
   logic             last_ff, last_in;
   logic [SW-1:0]    span_ff, span_in;

   logic [IW-1:0]    load_pos;
   logic             load_last;
   logic [IW-1:0]    final_pos;
   bracket_kind_type top_kind;
   logic [IW-1:0]    top_pos;
   logic [CW:0]      next_idx;
   logic [CW-1:0]    span_len;
   logic [SW+LEN_W-1:0] span_wide;

   assign load_pos  = count_ff[IW-1:0];
   assign load_last = req.is_final || (count_ff == CW'(MAX_LEN - 1));
   assign final_pos = IW'(count_ff - CW'(1));
   assign top_kind  = bracket_kind_type'(stk_rdata[KIND_W+IW-1:IW]);
   assign top_pos   = stk_rdata[IW-1:0];
   assign next_idx  = {{(CW+1-IW){1'b0}}, idx_ff} + {1'b0, span_rdata};
   assign span_len  = {{(CW-IW){1'b0}}, pos_ff} - {{(CW-IW){1'b0}}, top_pos} + CW'(1);
   assign span_wide = {{LEN_W{1'b0}}, span_rdata};

   // Next state and memory controls
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      depth_in   = depth_ff;
      pos_in     = pos_ff;
      sym_in     = sym_ff;
      last_in    = last_ff;
      span_in    = span_ff;
      req.ready  = 1'b0;
      stk_we     = 1'b0;
      stk_waddr  = depth_ff[IW-1:0];
      stk_wdata  = {opener_kind(req.symbol), load_pos};
      stk_re     = 1'b0;
      stk_raddr  = IW'(depth_ff - CW'(1));
      span_we    = 1'b0;
      span_waddr = idx_ff;
      span_wdata = '0;
      span_re    = 1'b0;
      span_raddr = idx_ff;
      out_load   = 1'b0;
      out_beat.span_length = span_wide[LEN_W-1:0];
      out_beat.end_of_run  = (idx_ff == final_pos);

      case (state_ff)
         // Zero the span store once after reset
         ST_CLEAR: begin
            span_we = 1'b1;
            if (idx_ff == IW'(MAX_LEN - 1)) begin
               idx_in   = '0;
               state_in = ST_LOAD;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end

         // Take one byte
         ST_LOAD: begin
            req.ready = 1'b1;
            if (req.valid) begin
               count_in = count_ff + CW'(1);
               if (is_opener(req.symbol)) begin
                  stk_we   = 1'b1;
                  depth_in = depth_ff + CW'(1);
                  if (load_last) begin
                     idx_in   = load_pos;
                     state_in = ST_BK_RD;
                  end
               end else if (depth_ff != '0) begin
                  stk_re   = 1'b1;
                  pos_in   = load_pos;
                  sym_in   = req.symbol;
                  last_in  = load_last;
                  state_in = ST_MATCH;
               end else if (load_last) begin
                  idx_in   = load_pos;
                  state_in = ST_BK_RD;
               end
            end
         end

         // Compare against the top opener: pop and record, or empty the stack
         ST_MATCH: begin
            if (closer_matches(top_kind, sym_ff)) begin
               span_we    = 1'b1;
               span_waddr = top_pos;
               span_wdata = span_len;
               depth_in   = depth_ff - CW'(1);
            end else begin
               depth_in = '0;
            end
            if (last_ff) begin
               idx_in   = pos_ff;
               state_in = ST_BK_RD;
            end else begin
               state_in = ST_LOAD;
            end
         end

         // Backward pass: read the span at this position
         ST_BK_RD: begin
            span_re  = 1'b1;
            state_in = ST_BK_NX;
         end

         // Fetch the span that follows, or move on
         ST_BK_NX: begin
            span_in = span_rdata;
            if ((span_rdata != '0) && (next_idx < {1'b0, count_ff})) begin
               span_re    = 1'b1;
               span_raddr = next_idx[IW-1:0];
               state_in   = ST_BK_WR;
            end else if (idx_ff == '0) begin
               state_in = ST_EM_RD;
            end else begin
               idx_in   = idx_ff - IW'(1);
               state_in = ST_BK_RD;
            end
         end

         // Chain the following span on
         ST_BK_WR: begin
            span_we    = 1'b1;
            span_wdata = span_ff + span_rdata;
            if (idx_ff == '0) begin
               state_in = ST_EM_RD;
            end else begin
               idx_in   = idx_ff - IW'(1);
               state_in = ST_BK_RD;
            end
         end

         // Emission: read the final span
         ST_EM_RD: begin
            span_re  = 1'b1;
            state_in = ST_EM_CAP;
         end

         // Hand the beat over and clear the entry behind it
         ST_EM_CAP: begin
            if (out_free) begin
               out_load = 1'b1;
               span_we  = 1'b1;
               if (idx_ff == final_pos) begin
                  idx_in   = '0;
                  count_in = '0;
                  depth_in = '0;
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = ST_EM_RD;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff   <= '0;
         count_ff <= '0;
         depth_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
         depth_ff <= depth_in;
      end
   end

   // Pending closer and partial span
   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      sym_ff  <= sym_in;
      last_ff <= last_in;
      span_ff <= span_in;
   end

endmodule

>>> rtl/core/balanced_bracket_span_top.sv
// Top level of the balanced bracket span block: controller, stack and span memories, output register.
//
// Bytes of a string arrive one per req beat. An opener or a byte met with an empty stack is handled
// in ST_LOAD alone; any other byte also passes through ST_MATCH, since the top opener comes out of
// the registered read port of the stack memory. On the last byte (is_final, or the MAX_LEN-th byte)
// a backward pass over the span memory goes through ST_BK_RD and ST_BK_NX at each position, and
// through ST_BK_WR as well where a span chains onto the next one, as the memory has a single read
// port. Emission then gives one rsp beat per stored position through ST_EM_RD and ST_EM_CAP, waits
// in ST_EM_CAP while rsp stalls, and clears each span entry as it goes. No byte is taken during the
// backward pass and emission. After reset, ST_CLEAR zeroes the span memory ahead of the first byte.
module balanced_bracket_span_top
   import bbs_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic      clock,
   input  logic      reset,
   bbs_req_if.sink   req_chan,
   bbs_rsp_if.source rsp_chan
);

   localparam int IW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int STK_W = KIND_W + IW;

   logic             stk_we;
   logic [IW-1:0]    stk_waddr;
   logic [STK_W-1:0] stk_wdata;
   logic             stk_re;
   logic [IW-1:0]    stk_raddr;
   logic [STK_W-1:0] stk_rdata;

   logic             span_we;
   logic [IW-1:0]    span_waddr;
   logic [CW-1:0]    span_wdata;
   logic             span_re;
   logic [IW-1:0]    span_raddr;
   logic [CW-1:0]    span_rdata;

   logic             out_free;
   logic             out_load;
   bbs_beat_type     out_beat;

   // Sequencer
   bbs_ctrl #(
      .MAX_LEN (MAX_LEN)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .stk_we     (stk_we),
      .stk_waddr  (stk_waddr),
      .stk_wdata  (stk_wdata),
      .stk_re     (stk_re),
      .stk_raddr  (stk_raddr),
      .stk_rdata  (stk_rdata),
      .span_we    (span_we),
      .span_waddr (span_waddr),
      .span_wdata (span_wdata),
      .span_re    (span_re),
      .span_raddr (span_raddr),
      .span_rdata (span_rdata),
      .out_free   (out_free),
      .out_load   (out_load),
      .out_beat   (out_beat)
   );

   // Pending openers: kind and position
   bbs_ram #(
      .WIDTH (STK_W),
      .DEPTH (MAX_LEN)
   ) u_stack_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .re    (stk_re),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   // Span lengths per position
   bbs_ram #(
      .WIDTH (CW),
      .DEPTH (MAX_LEN)
   ) u_span_ram (
      .clock (clock),
      .we    (span_we),
      .waddr (span_waddr),
      .wdata (span_wdata),
      .re    (span_re),
      .raddr (span_raddr),
      .rdata (span_rdata)
   );

   // Result register
   bbs_out_stage u_out (
      .clock (clock),
      .reset (reset),
      .load  (out_load),
      .beat  (out_beat),
      .free  (out_free),
      .rsp   (rsp_chan)
   );

endmodule
